@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/kthq_pkg.sv @@
package kthq_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int VALUE_BITS    = 32;
  localparam int RANK_BITS     = 11;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_BAD_RANK = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_PIV,
    S_LD_PIV,
    S_RD_SCAN,
    S_CMP,
    S_SWAP1,
    S_SWAP2,
    S_FIN_A,
    S_FIN_B
  } kthq_state_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RANK_BITS-1:0]         rank;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] selected;
    status_t                      status;
  } out_item_t;

endpackage

@@ design/kthq_store.sv @@
module kthq_store
  import kthq_pkg::*;
#(
  parameter int DEPTH = MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [VALUE_BITS-1:0]         wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [VALUE_BITS-1:0]         rd_data
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/kth_largest_quickselect.sv @@
// channel   ports                         handshake
// --------  ----------------------------  ------------------------------------
// input     in_item (value, rank, last)   taken when start is high, busy low
// result    out_item (selected, status)   valid for one cycle while out_valid
//
// loading takes one cycle per item; busy holds off input while selection runs
// lomuto quickselect over one store with a registered read port: each pass
//   reads the last element as pivot, scans the range, swaps each smaller
//   element down to the store pointer and ends with an exchange of the pivot
// rank or overflow errors found at load answer in the cycle after the last item
// reset clears control only, store undefined until loaded; receiver cannot stall
module kth_largest_quickselect
  import kthq_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

`include "assert_macros.svh"

  localparam int IW   = $clog2(MAX_ITEMS);
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > RANK_BITS) ? CW : RANK_BITS;

  kthq_state_t state_r, state_nxt;

  // element count and overflow flag of the set being loaded
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;

  // partition bounds, scan and store pointers, target index
  logic [IW-1:0]         lo_r, lo_nxt;
  logic [IW-1:0]         hi_r, hi_nxt;
  logic [IW-1:0]         sc_r, sc_nxt;
  logic [IW-1:0]         st_r, st_nxt;
  logic [IW-1:0]         goal_r, goal_nxt;
  logic [VALUE_BITS-1:0] pivot_r, pivot_nxt;
  logic [VALUE_BITS-1:0] cur_r, cur_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // store port
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  // load side decode
  logic                  accept;
  logic                  room;
  logic [CW-1:0]         count_new;
  logic                  ovf_now;
  logic [CMPW-1:0]       rank_w;
  logic [CMPW-1:0]       cnt_w;
  logic                  bad_rank;

  // partition side decode
  logic                  less;
  logic [IW-1:0]         sc_inc;
  logic [IW-1:0]         st_inc;
  logic [IW-1:0]         st_dec;
  logic [IW-1:0]         lo_cand;
  logic [IW-1:0]         hi_cand;

  kthq_store #(
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the last item is stored first, then counted into the rank check
  assign room      = (count_r < CW'(MAX_ITEMS));
  assign count_new = count_r + CW'(room);
  assign ovf_now   = ovf_r || !room;
  assign rank_w    = CMPW'(in_item.rank);
  assign cnt_w     = CMPW'(count_new);
  assign bad_rank  = (in_item.rank == '0) || (rank_w > cnt_w);

  // signed order against the pivot
  assign less   = ($signed(rd_data) < $signed(pivot_r));
  assign sc_inc = sc_r + IW'(1);
  assign st_inc = st_r + IW'(1);
  assign st_dec = st_r - IW'(1);

  // bounds after the pivot has landed at st
  always_comb begin
    lo_cand = lo_r;
    hi_cand = hi_r;
    if (st_r < goal_r) begin
      lo_cand = st_inc;
    end else begin
      hi_cand = st_dec;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.last && !ovf_now && !bad_rank) begin
          state_nxt = S_RD_PIV;
        end
      end
      S_RD_PIV:  state_nxt = S_LD_PIV;
      S_LD_PIV:  state_nxt = S_RD_SCAN;
      S_RD_SCAN: begin
        // past the scan, read the store slot for the final exchange
        state_nxt = (sc_r < hi_r) ? S_CMP : S_FIN_A;
      end
      S_CMP: begin
        if (less) begin
          state_nxt = (st_r == sc_r) ? S_RD_SCAN : S_SWAP1;
        end else if (sc_inc < hi_r) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_RD_SCAN;
        end
      end
      S_SWAP1:   state_nxt = S_SWAP2;
      S_SWAP2:   state_nxt = S_RD_SCAN;
      S_FIN_A:   state_nxt = S_FIN_B;
      S_FIN_B: begin
        if (st_r == goal_r || lo_cand > hi_cand) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD_PIV;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sc_nxt        = sc_r;
    st_nxt        = st_r;
    goal_nxt      = goal_r;
    pivot_nxt     = pivot_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = st_r;
    wr_data       = pivot_r;
    rd_en         = 1'b0;
    rd_addr       = sc_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          wr_en     = room;
          wr_addr   = count_r[IW-1:0];
          wr_data   = in_item.value;
          count_nxt = count_new;
          ovf_nxt   = ovf_now;
          if (in_item.last) begin
            // the set is closed either way; next item starts a new one
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            lo_nxt    = '0;
            hi_nxt    = IW'(count_new - CW'(1));
            goal_nxt  = IW'(cnt_w - rank_w);
            if (ovf_now) begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.selected = '0;
              out_item_nxt.status   = ST_OVERFLOW;
            end else if (bad_rank) begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.selected = '0;
              out_item_nxt.status   = ST_BAD_RANK;
            end
          end
        end
      end
      S_RD_PIV: begin
        // pivot is the last element of the range
        rd_en   = 1'b1;
        rd_addr = hi_r;
      end
      S_LD_PIV: begin
        pivot_nxt = rd_data;
        st_nxt    = lo_r;
        sc_nxt    = lo_r;
      end
      S_RD_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = (sc_r < hi_r) ? sc_r : st_r;
      end
      S_CMP: begin
        if (less) begin
          if (st_r == sc_r) begin
            st_nxt = st_inc;
            sc_nxt = sc_inc;
          end else begin
            cur_nxt = rd_data;
            rd_en   = 1'b1;
            rd_addr = st_r;
          end
        end else begin
          // keep streaming reads while no swap is needed
          sc_nxt  = sc_inc;
          rd_en   = (sc_inc < hi_r);
          rd_addr = sc_inc;
        end
      end
      S_SWAP1: begin
        wr_en   = 1'b1;
        wr_addr = sc_r;
        wr_data = rd_data;
      end
      S_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = st_r;
        wr_data = cur_r;
        st_nxt  = st_inc;
        sc_nxt  = sc_inc;
      end
      S_FIN_A: begin
        // the slot at hi still holds the pivot, so only one read is needed
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = rd_data;
      end
      S_FIN_B: begin
        wr_en   = 1'b1;
        wr_addr = st_r;
        wr_data = pivot_r;
        lo_nxt  = lo_cand;
        hi_nxt  = hi_cand;
        if (st_r == goal_r) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.selected = pivot_r;
          out_item_nxt.status   = ST_FOUND;
        end else if (lo_cand > hi_cand) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.selected = '0;
          out_item_nxt.status   = ST_BAD_RANK;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and pointers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sc_r       <= sc_nxt;
    st_r       <= st_nxt;
    goal_r     <= goal_nxt;
    pivot_r    <= pivot_nxt;
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
  end

  // checks
  `ASSERT_IMP(a_result_when_idle, out_valid_r, state_r == S_IDLE, "result while selection runs")
  `ASSERT_NXT(a_no_result_mid_set, accept && !in_item.last, !out_valid_r, "result on non-last item")
  `ASSERT_IMP(a_err_zero, out_valid_r && out_item_r.status != ST_FOUND, out_item_r.selected == '0, "nonzero value with error status")
  `ASSERT_IMP(a_range_order, state_r != S_IDLE, lo_r <= hi_r && goal_r <= hi_r && lo_r <= goal_r, "selection range lost the target")

endmodule
